>>> rtl/sof_crc16_frame_decoder_assert.svh
// Assertion macros used by the frame decoder top level.
`ifndef SOF_CRC16_FRAME_DECODER_ASSERT_SVH
`define SOF_CRC16_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SOFCRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SOFCRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sofcrc_pkg.sv
// Shared constants, register codes and interface structs of the frame decoder.
package sofcrc_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int HDR_BYTES   = 6;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Register reset values.
    localparam logic [7:0]       SOF_FIRST_RST  = 8'hAA;
    localparam logic [7:0]       SOF_SECOND_RST = 8'h55;
    localparam logic [15:0]      CRC_INIT_RST   = 16'hFFFF;
    localparam logic [LEN_W-1:0] CAPACITY_RST   = LEN_W'(MAX_PAYLOAD);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SOF_FIRST  = 2'd0,
        CFG_SOF_SECOND = 2'd1,
        CFG_CRC_INIT   = 2'd2,
        CFG_CAPACITY   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]       sof_first;
        logic [7:0]       sof_second;
        logic [15:0]      crc_init;
        logic [LEN_W-1:0] capacity;
    } cfg_t;

    // Header fields handed from the receiver to the output sequencer.
    typedef struct packed {
        logic [7:0] version;
        logic [7:0] node_id;
        logic [7:0] message_type;
        logic [7:0] sequence_no;
    } hdr_t;

    // Request to play out one good frame.
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] length;
        logic             zero;
    } drain_req_t;

endpackage

>>> rtl/sofcrc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module sofcrc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sofcrc_rx.sv
// Frame receiver: start-pair hunt, header capture, payload buffering and CRC check.
module sofcrc_rx
    import sofcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              mem_we,
    output logic [PAY_AW-1:0] mem_waddr,
    output logic [7:0]        mem_wdata,
    output hdr_t              hdr,
    output drain_req_t        drain_req
);

    typedef enum logic [5:0] {
        PH_SOF0 = 6'b000001,
        PH_SOF1 = 6'b000010,
        PH_HDR  = 6'b000100,
        PH_PAY  = 6'b001000,
        PH_CRC0 = 6'b010000,
        PH_CRC1 = 6'b100000
    } phase_t;

    localparam int HCNT_W = $clog2(HDR_BYTES);
    localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HDR_BYTES - 1);

    phase_t             phase_reg, phase_next;
    logic [HCNT_W-1:0]  hcnt_reg, hcnt_next;
    logic [LEN_W-1:0]   flen_reg, flen_next;
    logic [LEN_W-1:0]   pcnt_reg, pcnt_next;
    logic [LEN_W-1:0]   pcnt_inc;
    logic [7:0]         crc_hi_reg, crc_hi_next;
    logic [15:0]        crc_reg, crc_next;
    logic [15:0]        crc_upd;
    logic [7:0]         hdr_reg [0:HDR_BYTES-2];
    logic               len_too_big;
    logic               frame_good;

    // One CRC-16 byte update, MSB first.
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign crc_upd  = crc_add(crc_reg, rx_byte);
    assign pcnt_inc = pcnt_reg + LEN_W'(1);

    // The length high byte is held; the low byte is the word now arriving.
    assign len_too_big = (hdr_reg[HDR_BYTES-2] != 8'h00) || (rx_byte > 8'(MAX_PAYLOAD));
    assign frame_good  = ({crc_hi_reg, rx_byte} == crc_reg) && (flen_reg <= cfg.capacity);

    // Phase sequencing.
    always_comb
    begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        flen_next   = flen_reg;
        pcnt_next   = pcnt_reg;
        crc_hi_next = crc_hi_reg;
        crc_next    = crc_reg;
        mem_we      = 1'b0;
        drain_req   = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SOF0:
                begin
                    if (rx_byte == cfg.sof_first)
                    begin
                        phase_next = PH_SOF1;
                    end
                end
                PH_SOF1:
                begin
                    if (rx_byte == cfg.sof_second)
                    begin
                        phase_next = PH_HDR;
                        hcnt_next  = '0;
                        crc_next   = cfg.crc_init;
                    end
                    else if (rx_byte != cfg.sof_first)
                    begin
                        phase_next = PH_SOF0;
                    end
                end
                PH_HDR:
                begin
                    crc_next = crc_upd;
                    if (hcnt_reg != HCNT_LAST)
                    begin
                        hcnt_next = hcnt_reg + HCNT_W'(1);
                    end
                    else if (len_too_big)
                    begin
                        phase_next = PH_SOF0;
                        hcnt_next  = '0;
                        pcnt_next  = '0;
                        flen_next  = '0;
                    end
                    else
                    begin
                        flen_next  = rx_byte[LEN_W-1:0];
                        pcnt_next  = '0;
                        phase_next = (rx_byte == 8'h00) ? PH_CRC0 : PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    mem_we    = 1'b1;
                    pcnt_next = pcnt_inc;
                    crc_next  = crc_upd;
                    if (pcnt_inc >= flen_reg)
                    begin
                        phase_next = PH_CRC0;
                    end
                end
                PH_CRC0:
                begin
                    crc_hi_next = rx_byte;
                    phase_next  = PH_CRC1;
                end
                PH_CRC1:
                begin
                    phase_next = PH_SOF0;
                    hcnt_next  = '0;
                    pcnt_next  = '0;
                    flen_next  = '0;
                    if (frame_good)
                    begin
                        drain_req.start  = 1'b1;
                        drain_req.length = flen_reg;
                        drain_req.zero   = (flen_reg == '0);
                        drain_req.count  = (flen_reg == '0) ? LEN_W'(1) : flen_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_SOF0;
                    hcnt_next  = '0;
                    pcnt_next  = '0;
                    flen_next  = '0;
                end
            endcase
        end
    end

    assign mem_waddr = pcnt_reg[PAY_AW-1:0];
    assign mem_wdata = rx_byte;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOF0;
            hcnt_reg   <= '0;
            flen_reg   <= '0;
            pcnt_reg   <= '0;
            crc_hi_reg <= '0;
            crc_reg    <= CRC_INIT_RST;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            flen_reg   <= flen_next;
            pcnt_reg   <= pcnt_next;
            crc_hi_reg <= crc_hi_next;
            crc_reg    <= crc_next;
        end
    end

    // Header bytes; the last one is never needed after the length check.
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_HDR) && (hcnt_reg != HCNT_LAST))
        begin
            hdr_reg[hcnt_reg] <= rx_byte;
        end
    end

    assign hdr.version      = hdr_reg[0];
    assign hdr.node_id      = hdr_reg[1];
    assign hdr.message_type = hdr_reg[2];
    assign hdr.sequence_no  = hdr_reg[3];

endmodule

>>> rtl/sofcrc_tx.sv
// Output sequencer: reads buffered payload bytes and presents one result word each.
module sofcrc_tx
    import sofcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  drain_req_t        drain_req,
    input  hdr_t              hdr,
    input  logic [7:0]        rd_data,
    output logic              rd_en,
    output logic [PAY_AW-1:0] rd_addr,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        version,
    output logic [7:0]        node_id,
    output logic [7:0]        message_type,
    output logic [7:0]        sequence_res,
    output logic [LEN_W-1:0]  payload_length,
    output logic [7:0]        payload_byte,
    output logic [PAY_AW-1:0] byte_index,
    output logic              last
);

    logic [LEN_W-1:0]  left_reg, left_next;
    logic [PAY_AW-1:0] idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [PAY_AW-1:0] pend_idx_reg;
    logic              pend_last_reg;
    logic              zero_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;
    logic              issue;

    // A read is issued when its data has somewhere to go next cycle.
    assign out_load = pend_reg && (!out_valid_reg || out_ready);
    assign issue    = (left_reg != '0) && (!pend_reg || out_load);
    assign rd_en    = issue;
    assign rd_addr  = idx_reg;
    assign busy     = (left_reg != '0) || pend_reg;

    always_comb
    begin
        left_next      = left_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (drain_req.start)
        begin
            left_next = drain_req.count;
            idx_next  = '0;
        end
        else if (issue)
        begin
            left_next = left_reg - LEN_W'(1);
            idx_next  = idx_reg + PAY_AW'(1);
        end
        if (issue)
        begin
            pend_next = 1'b1;
        end
        else if (out_load)
        begin
            pend_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Frame attributes and the tag of the read in flight.
    always_ff @(posedge clk)
    begin
        if (drain_req.start)
        begin
            zero_reg <= drain_req.zero;
            len_reg  <= drain_req.length;
        end
        if (issue)
        begin
            pend_idx_reg  <= idx_reg;
            pend_last_reg <= (left_reg == LEN_W'(1));
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            version        <= hdr.version;
            node_id        <= hdr.node_id;
            message_type   <= hdr.message_type;
            sequence_res   <= hdr.sequence_no;
            payload_length <= len_reg;
            payload_byte   <= zero_reg ? 8'h00 : rd_data;
            byte_index     <= pend_idx_reg;
            last           <= pend_last_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/sof_crc16_frame_decoder.sv
// Top level of the CRC-16 framed packet decoder.
// Receiving: one byte word per cycle; in_ready is high whenever no frame is being played out.
// First result: a good frame's first result passes the playout counter, the RAM read register and the output register.
// Playout: max(length, 1) result words, one per cycle while out_ready stays high, set by
// the single read port of the payload RAM; input is held off until every read is done.
// Reset: rst_n sets all control state and the configuration registers to their reset values at once;
// the payload RAM is not cleared, as every entry that is played out is written before it is read.
module sof_crc16_frame_decoder
    import sofcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        version,
    output logic [7:0]        node_id,
    output logic [7:0]        message_type,
    output logic [7:0]        sequence_res,
    output logic [LEN_W-1:0]  payload_length,
    output logic [7:0]        payload_byte,
    output logic [PAY_AW-1:0] byte_index,
    output logic              last
);

    `include "sof_crc16_frame_decoder_assert.svh"

    cfg_t              cfg_reg;
    logic              in_accept;
    logic              mem_we;
    logic [PAY_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [PAY_AW-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    hdr_t              hdr;
    drain_req_t        drain_req;
    logic              tx_busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_first  <= SOF_FIRST_RST;
            cfg_reg.sof_second <= SOF_SECOND_RST;
            cfg_reg.crc_init   <= CRC_INIT_RST;
            cfg_reg.capacity   <= CAPACITY_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SOF_FIRST:  cfg_reg.sof_first  <= cfg_data[7:0];
                CFG_SOF_SECOND: cfg_reg.sof_second <= cfg_data[7:0];
                CFG_CRC_INIT:   cfg_reg.crc_init   <= cfg_data;
                CFG_CAPACITY:   cfg_reg.capacity   <= cfg_data[LEN_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Input is interlocked against playout, so RAM writes and reads never overlap.
    assign in_ready  = !tx_busy;
    assign in_accept = in_valid && in_ready;

    sofcrc_rx u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (in_accept),
        .rx_byte   (in_byte),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .hdr       (hdr),
        .drain_req (drain_req)
    );

    sofcrc_ram #(
        .DATA_W (8),
        .ADDR_W (PAY_AW)
    ) u_payload_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sofcrc_tx u_tx (
        .clk            (clk),
        .rst_n          (rst_n),
        .drain_req      (drain_req),
        .hdr            (hdr),
        .rd_data        (mem_rdata),
        .rd_en          (mem_re),
        .rd_addr        (mem_raddr),
        .busy           (tx_busy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .version        (version),
        .node_id        (node_id),
        .message_type   (message_type),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

    // A new playout starts only when the previous one has drained.
    `SOFCRC_ASSERT_NOW(a_start_when_idle, drain_req.start, !tx_busy, "playout started while busy")

    // The payload RAM is never written while a playout is reading it.
    `SOFCRC_ASSERT_NOW(a_no_write_in_playout, mem_we, !mem_re && !tx_busy, "RAM write during playout")

    // The final word of a frame carries the last index of its payload.
    `SOFCRC_ASSERT_NOW(a_last_index, out_valid && last, (payload_length == '0 && byte_index == '0) || (({1'b0, byte_index} + 7'd1) == payload_length), "last word index mismatch")

    // A good frame makes the output sequencer busy from the next cycle on.
    `SOFCRC_ASSERT_NEXT(a_start_busy, drain_req.start, tx_busy, "playout did not start")

endmodule

>>> tb/sv/tb_sof_crc16_frame_decoder.sv
// Self-checking testbench for the CRC-16 framed packet decoder.
`timescale 1ns / 1ps

module tb_sof_crc16_frame_decoder;
    import sofcrc_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    localparam int HANG_LIMIT  = 2000;
    // Settling time after the last expected word.
    localparam int DRAIN_PAUSE = 8;
    localparam int PRINT_CAP   = 30;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        IN_HEADER,
        IN_PAYLOAD,
        CRC_HIGH,
        CRC_LOW
    } rx_phase_t;

    typedef struct packed {
        logic [7:0]        version;
        logic [7:0]        node_id;
        logic [7:0]        message_type;
        logic [7:0]        sequence_res;
        logic [LEN_W-1:0]  payload_length;
        logic [7:0]        payload_byte;
        logic [PAY_AW-1:0] byte_index;
        logic              last;
    } frame_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    cfg_idx_t          cfg_index = CFG_SOF_FIRST;
    logic [15:0]       cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        in_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        version;
    logic [7:0]        node_id;
    logic [7:0]        message_type;
    logic [7:0]        sequence_res;
    logic [LEN_W-1:0]  payload_length;
    logic [7:0]        payload_byte;
    logic [PAY_AW-1:0] byte_index;
    logic              last;

    // Configuration as the block should currently hold it.
    logic [7:0]        cur_first = SOF_FIRST_RST;
    logic [7:0]        cur_second = SOF_SECOND_RST;
    logic [15:0]       cur_crc_init = CRC_INIT_RST;
    logic [LEN_W-1:0]  cur_capacity = CAPACITY_RST;

    // Receiver state of the predictor.
    rx_phase_t         rx_phase = HUNT_FIRST;
    int                hdr_count = 0;
    logic [7:0]        hdr_bytes [HDR_BYTES];
    logic [LEN_W-1:0]  frame_len = '0;
    int                pay_count = 0;
    logic [7:0]        pay_bytes [MAX_PAYLOAD];
    logic [7:0]        crc_hi = '0;
    logic [15:0]       crc_acc = CRC_INIT_RST;

    frame_word_t       pending_words [$];
    int                error_count = 0;
    int                idle_cycles = 0;
    int                bytes_sent = 0;
    bit                in_idle_on = 1'b1;
    bit                out_idle_on = 1'b1;

    sof_crc16_frame_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .version        (version),
        .node_id        (node_id),
        .message_type   (message_type),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

    // Clock generation.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // One CRC-16 step, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // A byte that can neither start nor continue a start pair.
    function automatic logic [7:0] quiet_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom);
        end
        while (b == cur_first || b == cur_second);
        return b;
    endfunction

    // Advances the deframer prediction by one accepted byte and queues its results.
    task automatic advance_deframer(input logic [7:0] b);
        logic [15:0] hdr_len;
        frame_word_t w;
        logic        good;
        int          n;
        case (rx_phase)
            HUNT_FIRST:
            begin
                if (b == cur_first)
                    rx_phase = HUNT_SECOND;
            end
            HUNT_SECOND:
            begin
                // The second marker is tested first, so equal markers start a header.
                if (b == cur_second)
                begin
                    rx_phase  = IN_HEADER;
                    hdr_count = 0;
                    crc_acc   = cur_crc_init;
                end
                else if (b != cur_first)
                begin
                    rx_phase = HUNT_FIRST;
                end
            end
            IN_HEADER:
            begin
                hdr_bytes[hdr_count] = b;
                hdr_count++;
                crc_acc = crc16_step(crc_acc, b);
                if (hdr_count == HDR_BYTES)
                begin
                    hdr_len = {hdr_bytes[4], hdr_bytes[5]};
                    if (hdr_len > MAX_PAYLOAD)
                    begin
                        rx_phase = HUNT_FIRST;
                    end
                    else
                    begin
                        frame_len = hdr_len[LEN_W-1:0];
                        pay_count = 0;
                        rx_phase  = (hdr_len == 0) ? CRC_HIGH : IN_PAYLOAD;
                    end
                end
            end
            IN_PAYLOAD:
            begin
                pay_bytes[pay_count] = b;
                pay_count++;
                crc_acc = crc16_step(crc_acc, b);
                if (pay_count >= frame_len)
                    rx_phase = CRC_HIGH;
            end
            CRC_HIGH:
            begin
                crc_hi   = b;
                rx_phase = CRC_LOW;
            end
            default:
            begin
                // Good CRC and a length within capacity release the frame.
                good     = ({crc_hi, b} == crc_acc) && (frame_len <= cur_capacity);
                rx_phase = HUNT_FIRST;
                if (good)
                begin
                    n = (frame_len == 0) ? 1 : int'(frame_len);
                    for (int k = 0; k < n; k++)
                    begin
                        w.version        = hdr_bytes[0];
                        w.node_id        = hdr_bytes[1];
                        w.message_type   = hdr_bytes[2];
                        w.sequence_res   = hdr_bytes[3];
                        w.payload_length = frame_len;
                        w.payload_byte   = (frame_len == 0) ? 8'h00 : pay_bytes[k];
                        w.byte_index     = PAY_AW'(k);
                        w.last           = (k == n - 1);
                        pending_words.push_back(w);
                    end
                end
            end
        endcase
    endtask

    // Sends one byte word; called at a falling edge and returns at one.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid = 1'b1;
        in_byte  = b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        advance_deframer(b);
        bytes_sent++;
        @(negedge clk);
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stops the input and lets every expected word drain out.
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (pending_words.size() > 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // Writes one configuration register and tracks its masked value.
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_SOF_FIRST:  cur_first    = val[7:0];
            CFG_SOF_SECOND: cur_second   = val[7:0];
            CFG_CRC_INIT:   cur_crc_init = val;
            CFG_CAPACITY:   cur_capacity = val[LEN_W-1:0];
            default:        ;
        endcase
    endtask

    // Sends a start pair, header, payload and CRC; an oversize length stops after the header.
    task automatic send_frame(input logic [7:0] ver, input logic [7:0] node,
                              input logic [7:0] kind, input logic [7:0] seq,
                              input logic [15:0] len_field, input bit bad_crc);
        logic [7:0]  hdr [HDR_BYTES];
        logic [7:0]  pb;
        logic [15:0] crc;
        hdr[0] = ver;
        hdr[1] = node;
        hdr[2] = kind;
        hdr[3] = seq;
        hdr[4] = len_field[15:8];
        hdr[5] = len_field[7:0];
        crc = cur_crc_init;
        send_byte(cur_first);
        send_byte(cur_second);
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            send_byte(hdr[i]);
            crc = crc16_step(crc, hdr[i]);
        end
        if (len_field > MAX_PAYLOAD)
            return;
        for (int i = 0; i < int'(len_field); i++)
        begin
            pb = 8'($urandom);
            send_byte(pb);
            crc = crc16_step(crc, pb);
        end
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
    endtask

    task automatic random_frame(input logic [15:0] len_field, input bit bad_crc);
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), len_field, bad_crc);
    endtask

    // Mix of good frames, damaged frames and line noise for a number of bytes.
    task automatic run_traffic(input int budget);
        int start;
        int kind;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
                random_frame(16'(n), 1'b0);
            end
            else if (kind == 6)
            begin
                random_frame(16'($urandom_range(0, 8)), 1'b1);
            end
            else if (kind == 7)
            begin
                random_frame(16'($urandom_range(MAX_PAYLOAD + 1, 65535)), 1'b0);
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(quiet_byte());
            end
            else
            begin
                // Raw noise, then enough quiet bytes to bring the hunt back.
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom));
                while (rx_phase != HUNT_FIRST)
                    send_byte(quiet_byte());
            end
        end
    endtask

    // Empty payload, repeated first marker, oversize lengths and a bad CRC.
    task automatic test_directed_frames();
        send_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 16'd0, 1'b0);
        send_byte(cur_first);
        send_byte(cur_first);
        send_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd1, 1'b0);
        random_frame(16'd65, 1'b0);
        random_frame(16'h8000, 1'b0);
        random_frame(16'd2, 1'b1);
        wait_quiet();
    endtask

    // Frames at and beyond the receive capacity, including the largest payload.
    task automatic test_capacity_limits();
        write_reg(CFG_CAPACITY, 16'd0);
        random_frame(16'd0, 1'b0);
        random_frame(16'd1, 1'b0);
        wait_quiet();
        write_reg(CFG_CAPACITY, 16'd3);
        random_frame(16'd3, 1'b0);
        random_frame(16'd4, 1'b0);
        wait_quiet();
        write_reg(CFG_CAPACITY, 16'(MAX_PAYLOAD));
        random_frame(16'(MAX_PAYLOAD), 1'b0);
        wait_quiet();
    endtask

    // Equal markers, extreme marker values, CRC seeds at both ends, masked writes.
    task automatic test_marker_settings();
        write_reg(CFG_SOF_FIRST, 16'hA57E);
        write_reg(CFG_SOF_SECOND, 16'h007E);
        write_reg(CFG_CRC_INIT, 16'h0000);
        random_frame(16'd2, 1'b0);
        random_frame(16'd0, 1'b0);
        wait_quiet();
        write_reg(CFG_SOF_FIRST, 16'h0000);
        write_reg(CFG_SOF_SECOND, 16'hFFFF);
        write_reg(CFG_CRC_INIT, 16'hFFFF);
        // A first marker followed by a non-marker drops back to the hunt.
        send_byte(8'h00);
        send_byte(8'h12);
        random_frame(16'd1, 1'b0);
        random_frame(16'd0, 1'b0);
        wait_quiet();
    endtask

    // Random settings with random traffic, the last stretch without idling.
    task automatic test_random_traffic();
        logic [15:0] first_val;
        for (int s = 0; s < 2; s++)
        begin
            first_val = 16'($urandom);
            write_reg(CFG_SOF_FIRST, first_val);
            write_reg(CFG_SOF_SECOND,
                      ($urandom_range(0, 3) == 0) ? first_val : 16'($urandom));
            write_reg(CFG_CRC_INIT, 16'($urandom));
            write_reg(CFG_CAPACITY, ($urandom_range(0, 2) == 0) ?
                      16'($urandom_range(0, 8)) : 16'($urandom_range(9, MAX_PAYLOAD)));
            in_idle_on  = ($urandom_range(0, 2) != 0);
            out_idle_on = ($urandom_range(0, 2) != 0);
            run_traffic(4);
            wait_quiet();
        end
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        write_reg(CFG_CAPACITY, 16'(MAX_PAYLOAD));
        run_traffic(8);
        wait_quiet();
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Output side stalls in random bursts.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
            begin
                out_ready = 1'b1;
                if (out_idle_on && $urandom_range(0, 3) == 0)
                    stall = $urandom_range(1, 5);
            end
        end
    end

    // Compare each accepted result word with the oldest expected one.
    always @(posedge clk)
    begin : check_words
        frame_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch("result word with no expected word");
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("version", int'(version), int'(want.version));
                check_field("node_id", int'(node_id), int'(want.node_id));
                check_field("message_type", int'(message_type), int'(want.message_type));
                check_field("sequence_res", int'(sequence_res), int'(want.sequence_res));
                check_field("payload_length", int'(payload_length),
                            int'(want.payload_length));
                check_field("payload_byte", int'(payload_byte), int'(want.payload_byte));
                check_field("byte_index", int'(byte_index), int'(want.byte_index));
                check_field("last", int'(last), int'(want.last));
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_frames();
        test_capacity_limits();
        test_marker_settings();
        test_random_traffic();
        wait_quiet();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
